### rtl/qkc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qkc_pkg;

    // Width of the internal channel accumulator (8 to 16)
    localparam int CHANNEL_BITS  = 11;
    localparam int CHANNEL_BITS1 = CHANNEL_BITS + 1;

    // Fixed field and register widths
    localparam int CHAN_FIELD_W = 11;
    localparam int COUNT_W      = 16;
    localparam int STEP_W       = 2;
    localparam int STEP_SIZE_W  = 8;
    localparam int LIMIT_W      = 11;
    localparam int DETENT_W     = 3;
    localparam int SUM_W        = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 11;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_PAD_W    = OUT_TDATA_W - CHAN_FIELD_W - COUNT_W - STEP_W;

    // Compare width wide enough for both the channel and the 11-bit limits
    localparam int CMP_W = (CHANNEL_BITS > LIMIT_W) ? CHANNEL_BITS : LIMIT_W;

    // Register reset values
    localparam logic [STEP_SIZE_W-1:0] STEP_SIZE_RST   = 8'd25;
    localparam logic [LIMIT_W-1:0]     UPPER_LIMIT_RST = 11'd1792;
    localparam logic [LIMIT_W-1:0]     LOWER_LIMIT_RST = 11'd191;
    localparam logic [LIMIT_W-1:0]     START_VALUE_RST = 11'd1003;
    localparam logic [DETENT_W-1:0]    DETENT_RST      = 3'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_SIZE        = 3'd0,
        REG_UPPER_LIMIT      = 3'd1,
        REG_LOWER_LIMIT      = 3'd2,
        REG_START_VALUE      = 3'd3,
        REG_STEPS_PER_DETENT = 3'd4
    } t_reg_idx;

    typedef enum logic [STEP_W-1:0] {
        STEP_NONE = 2'b00,
        STEP_UP   = 2'b01,
        STEP_DOWN = 2'b11
    } t_step;

    typedef struct packed {
        logic [STEP_SIZE_W-1:0] step_size;
        logic [LIMIT_W-1:0]     upper_limit;
        logic [LIMIT_W-1:0]     lower_limit;
        logic [DETENT_W-1:0]    steps_per_detent;
    } t_cfg;

    // Direction per {previous phase, new phase}; illegal or idle moves give zero
    localparam logic signed [1:0] DIR_TABLE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

endpackage

`default_nettype wire

### rtl/qkc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module qkc_cfg_regs
    import qkc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size        <= STEP_SIZE_RST;
            r_cfg.upper_limit      <= UPPER_LIMIT_RST;
            r_cfg.lower_limit      <= LOWER_LIMIT_RST;
            r_cfg.steps_per_detent <= DETENT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_STEP_SIZE:        r_cfg.step_size        <= i_cfg_data[STEP_SIZE_W-1:0];
                REG_UPPER_LIMIT:      r_cfg.upper_limit      <= i_cfg_data[LIMIT_W-1:0];
                REG_LOWER_LIMIT:      r_cfg.lower_limit      <= i_cfg_data[LIMIT_W-1:0];
                // Reset also restores the start value, so the channel always
                // reloads the reset constant; nothing to store here.
                REG_START_VALUE:      ;
                REG_STEPS_PER_DETENT: r_cfg.steps_per_detent <= i_cfg_data[DETENT_W-1:0];
                default:              ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/qkc_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

module qkc_decoder
    import qkc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic [1:0]          i_phase,
    input  wire logic [DETENT_W-1:0] i_steps_per_detent,
    output t_step                    o_step
);

    logic [1:0]              r_last_phase;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;

    logic signed [1:0]       w_dir;
    logic signed [SUM_W:0]   w_sum_raw;
    logic signed [SUM_W:0]   w_sum_sat;
    logic [DETENT_W-1:0]     w_thr;
    logic signed [SUM_W:0]   w_thr_s;

    always_comb begin
        w_dir     = DIR_TABLE[{r_last_phase, i_phase}];
        w_sum_raw = {r_sum[SUM_W-1], r_sum} + {{(SUM_W-1){w_dir[1]}}, w_dir};
        if (w_sum_raw > 5'sd7) begin
            w_sum_sat = 5'sd7;
        end else if (w_sum_raw < -5'sd8) begin
            w_sum_sat = -5'sd8;
        end else begin
            w_sum_sat = w_sum_raw;
        end
        // A zero threshold behaves as one
        w_thr   = (i_steps_per_detent == '0) ? DETENT_W'(1) : i_steps_per_detent;
        w_thr_s = $signed({2'b00, w_thr});
    end

    always_comb begin
        if (w_sum_sat >= w_thr_s) begin
            o_step = STEP_UP;
            n_sum  = '0;
        end else if (w_sum_sat <= -w_thr_s) begin
            o_step = STEP_DOWN;
            n_sum  = '0;
        end else begin
            o_step = STEP_NONE;
            n_sum  = w_sum_sat[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= '0;
            r_sum        <= '0;
        end else if (i_adv) begin
            r_last_phase <= i_phase;
            r_sum        <= n_sum;
        end
    end

endmodule

`default_nettype wire

### rtl/qkc_channel.sv
`timescale 1ns / 1ps
`default_nettype none

module qkc_channel
    import qkc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  t_step                   i_step,
    input  t_cfg                    i_cfg,
    output logic [CHANNEL_BITS-1:0] o_channel_next,
    output logic [COUNT_W-1:0]      o_count_next
);

    logic [CHANNEL_BITS-1:0]  r_channel;
    logic [COUNT_W-1:0]       r_count;

    logic [CMP_W-1:0]         w_ch_ext;
    logic [CMP_W-1:0]         w_up_ext;
    logic [CMP_W-1:0]         w_lo_ext;
    logic [CMP_W-1:0]         w_start_ext;
    logic [CHANNEL_BITS-1:0]  w_step;
    logic [CHANNEL_BITS1-1:0] w_up_sum;

    always_comb begin
        w_ch_ext    = CMP_W'(r_channel);
        w_up_ext    = CMP_W'(i_cfg.upper_limit);
        w_lo_ext    = CMP_W'(i_cfg.lower_limit);
        w_start_ext = CMP_W'(START_VALUE_RST);
        w_step      = CHANNEL_BITS'(i_cfg.step_size);
        w_up_sum    = {1'b0, r_channel} + CHANNEL_BITS1'(w_step);
    end

    // Limits are tested against the value before the move
    always_comb begin
        o_channel_next = r_channel;
        o_count_next   = r_count;
        case (i_step)
            STEP_UP: begin
                o_count_next = r_count + COUNT_W'(1);
                if (w_ch_ext > w_up_ext) begin
                    o_channel_next = w_up_ext[CHANNEL_BITS-1:0];
                end else if (w_up_sum[CHANNEL_BITS]) begin
                    o_channel_next = '1;
                end else begin
                    o_channel_next = w_up_sum[CHANNEL_BITS-1:0];
                end
            end
            STEP_DOWN: begin
                o_count_next = r_count - COUNT_W'(1);
                if (w_ch_ext < w_lo_ext) begin
                    o_channel_next = w_lo_ext[CHANNEL_BITS-1:0];
                end else if (r_channel >= w_step) begin
                    o_channel_next = r_channel - w_step;
                end else begin
                    o_channel_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel <= w_start_ext[CHANNEL_BITS-1:0];
            r_count   <= '0;
        end else if (i_adv) begin
            r_channel <= o_channel_next;
            r_count   <= o_count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/quadrature_knob_channel_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Half-step quadrature decoder for a rotary knob driving a clamped channel
// value. Each input transaction is one sample of the A and B pins; each sample
// yields exactly one output transaction carrying the channel value, the wrapped
// signed rotation count and the step code (1 up, -1 down, 0 none). One sample
// is taken every clock unless the result stalls: a sample register feeds a
// combinational update of the transition accumulator, channel and count,
// registered into the state and the result register at once. A stalled
// result holds while the sample register still takes one more transaction.
// Configuration writes belong to idle periods; a start_value write has no
// effect, since reset always loads 1003.

module quadrature_knob_channel_top
    import qkc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Pin samples
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [0] phase_a_level, [1] phase_b_level, [7:2] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Results
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [10:0] channel_value, [26:11] rotation_count, [28:27] step_taken, [31:29] zero
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    t_cfg                    w_cfg;
    t_step                   w_step;
    logic [CHANNEL_BITS-1:0] w_ch_next;
    logic [COUNT_W-1:0]      w_count_next;
    logic [CMP_W-1:0]        w_ch_ext;
    logic                    w_adv;

    logic                    r_in_valid;
    logic [1:0]              r_in_phase;
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data;

    qkc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    qkc_decoder u_dec (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_adv              (w_adv),
        .i_phase            (r_in_phase),
        .i_steps_per_detent (w_cfg.steps_per_detent),
        .o_step             (w_step)
    );

    qkc_channel u_chan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_step         (w_step),
        .i_cfg          (w_cfg),
        .o_channel_next (w_ch_next),
        .o_count_next   (w_count_next)
    );

    // Advance the held sample whenever the result register is free or draining
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_ch_ext        = CMP_W'(w_ch_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            // phase = {A, B}
            r_in_phase <= {i_s_axis_tdata[0], i_s_axis_tdata[1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, w_step, w_count_next,
                           w_ch_ext[CHAN_FIELD_W-1:0]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // A held sample that cannot advance stays in place
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_phase)))
        else $error("sample register lost or changed a stalled sample");

    // Every advanced sample produces a result
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced sample produced no result");

    // Reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
